// ===== hw/rtl/wlg_pkg.sv =====
// Shared types and constants of the 5x5 window luminance gain filter.
// No dependencies.
package wlg_pkg;

  localparam int unsigned GainDiv  = 4876875;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned MinSize   = 5;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned GainW   = 9;
  localparam int unsigned WidthW  = 11;
  localparam int unsigned HeightW = 13;
  localparam int unsigned RowW    = 12;
  localparam int unsigned ColW    = 10;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 13;

  // Neighborhood sum of 25 pixels of r+g+b fits in 15 bits; times gain in 25
  localparam int unsigned TotalW  = 15;
  localparam int unsigned WeightW = 25;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

endpackage

// ===== hw/rtl/wlg_in_if.sv =====
// Input pixel channel: valid/ready handshake with one BGRA pixel.
// Depends on wlg_pkg.
interface wlg_in_if;
  logic                      valid;
  logic                      ready;
  logic [wlg_pkg::ChanW-1:0] blue_in;
  logic [wlg_pkg::ChanW-1:0] green_in;
  logic [wlg_pkg::ChanW-1:0] red_in;
  logic [wlg_pkg::ChanW-1:0] alpha_in;

  modport source (output valid, blue_in, green_in, red_in, alpha_in, input ready);
  modport sink   (input valid, blue_in, green_in, red_in, alpha_in, output ready);
endinterface

// ===== hw/rtl/wlg_out_if.sv =====
// Output channel: valid/ready handshake with one filtered pixel and its position.
// Depends on wlg_pkg.
interface wlg_out_if;
  logic                      valid;
  logic                      ready;
  logic [wlg_pkg::ChanW-1:0] blue_out;
  logic [wlg_pkg::ChanW-1:0] green_out;
  logic [wlg_pkg::ChanW-1:0] red_out;
  logic [wlg_pkg::ChanW-1:0] alpha_out;
  logic [wlg_pkg::RowW-1:0]  out_row;
  logic [wlg_pkg::ColW-1:0]  out_col;
  logic                      frame_last;

  modport source (output valid, blue_out, green_out, red_out, alpha_out, out_row, out_col,
                  frame_last, input ready);
  modport sink   (input valid, blue_out, green_out, red_out, alpha_out, out_row, out_col,
                  frame_last, output ready);
endinterface

// ===== hw/rtl/wlg_chan.sv =====
// One color channel: c + trunc(weighted * c / GainDiv), clamped to 0..255.
// Multiplies once, then divides by reciprocal multiplication and one correction step.
// Depends on wlg_pkg.
module wlg_chan (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [wlg_pkg::WeightW-1:0] weighted_i,
  input  logic        [wlg_pkg::ChanW-1:0]   chan_i,
  output logic                               done_o,
  output logic        [wlg_pkg::ChanW-1:0]   result_o
);

  localparam int unsigned MagW       = 31;
  localparam int unsigned ProdW      = wlg_pkg::WeightW + wlg_pkg::ChanW + 1;
  localparam int unsigned QuoW       = 9;
  localparam int unsigned EstW       = MagW + 10;
  localparam int unsigned RecipShift = 32;
  // floor(2^32 / GainDiv); the quotient estimate is low by at most one
  localparam logic [EstW-1:0] Recip = EstW'((64'd1 << RecipShift) / wlg_pkg::GainDiv);

  logic [1:0]                  stage_q;
  logic                        done_q;
  logic [MagW-1:0]             mag_q;
  logic                        neg_q;
  logic [QuoW-1:0]             est_q;
  logic [QuoW-1:0]             quo_q;
  logic [wlg_pkg::ChanW-1:0]   chan_q;

  logic signed [ProdW-1:0]     prod;
  logic [ProdW-1:0]            prod_abs;
  logic [EstW-1:0]             est;
  logic [MagW-1:0]             back;
  logic [MagW-1:0]             rem;
  logic signed [9:0]           sum;

  assign prod     = weighted_i * $signed({1'b0, chan_i});
  assign prod_abs = prod[ProdW-1] ? ProdW'(-prod) : ProdW'(prod);
  assign est      = EstW'(mag_q) * Recip;
  assign back     = MagW'(est_q) * MagW'(wlg_pkg::GainDiv);
  assign rem      = mag_q - back;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
      done_q  <= 1'b0;
    end else begin
      stage_q <= {stage_q[0], start_i};
      done_q  <= stage_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q  <= prod_abs[MagW-1:0];
      neg_q  <= prod[ProdW-1];
      chan_q <= chan_i;
    end
    if (stage_q[0]) begin
      est_q <= est[RecipShift +: QuoW];
    end
    if (stage_q[1]) begin
      // bump the estimate when a whole divisor is still left over
      quo_q <= (rem >= MagW'(wlg_pkg::GainDiv)) ? est_q + QuoW'(1) : est_q;
    end
  end

  always_comb begin
    sum = neg_q ? $signed({2'b00, chan_q}) - $signed({1'b0, quo_q})
                : $signed({2'b00, chan_q}) + $signed({1'b0, quo_q});
    if (sum[9]) begin
      result_o = '0;
    end else if (sum > 10'sd255) begin
      result_o = '1;
    end else begin
      result_o = sum[wlg_pkg::ChanW-1:0];
    end
  end

  assign done_o = done_q;

  a_done_after_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(stage_q[1])) else $error("done without a division in flight");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_q != 2'b00) |-> !start_i) else $error("start while dividing");
  a_start_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> stage_q[0]) else $error("division did not begin");

endmodule

// ===== hw/rtl/window_luminance_gain_filter_5x5_unit.sv =====
// 5x5 window luminance gain filter, top level.
// Depends on wlg_pkg, wlg_in_if, wlg_out_if and wlg_chan.
//
// Pixels enter in raster order on in_i (valid/ready); a transaction is one
// BGRA pixel. For each pixel at least two rows and columns inside every edge,
// one result leaves on out_o with its row and column; border pixels give none.
// frame_last marks the result made by the last pixel of a frame.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (gain,
// image_width, image_height); write only while the block is idle.
// Each pixel takes these steps: read the column word from the line memory, add
// and write it back; a pixel that gives no result ends there. Otherwise the
// window total is multiplied by the gain, the channel units take the product,
// divide by 4876875 by reciprocal multiplication and correct the quotient, the
// block sees them finish and loads the output register. The line memory
// holds, per column, four rows of r+g+b and two rows of pixels; a read and its
// write-back never overlap another access. A finished result waits in the
// output register; the next pixel is taken while it waits, and the block holds
// before its own output if the receiver still stalls. Reset clears counters,
// window sums and control state; the line memory needs no clearing. MAX_WIDTH
// is a power of two from 8 to 1024.
module window_luminance_gain_filter_5x5_unit #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  wlg_in_if.sink                             in_i,
  wlg_out_if.source                          out_o,
  input  logic                               cfg_we_i,
  input  logic [wlg_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [wlg_pkg::CfgDatW-1:0]        cfg_data_i
);

  localparam int unsigned AddrW = $clog2(MAX_WIDTH);
  localparam int unsigned SumW  = 10;
  localparam int unsigned ColSW = 13;
  localparam int unsigned PixW  = 32;
  localparam int unsigned WordW = 4 * SumW + 2 * PixW;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_MUL, S_CHAN, S_DONE} state_e;

  state_e state_q;

  logic signed [wlg_pkg::GainW-1:0]  gain_q;
  logic [wlg_pkg::WidthW-1:0]        width_q;
  logic [wlg_pkg::HeightW-1:0]       height_q;

  logic [wlg_pkg::ColW-1:0]          col_cnt_q;
  logic [wlg_pkg::RowW-1:0]          row_cnt_q;

  logic [WordW-1:0]                  mem [MAX_WIDTH];
  logic [WordW-1:0]                  rdata_q;
  logic [AddrW-1:0]                  addr_q;
  logic [1:0]                        lane_q;
  logic [SumW-1:0]                   s_q;
  logic [PixW-1:0]                   pix_q;
  logic                              interior_q;
  logic                              last_q;
  logic [wlg_pkg::RowW-1:0]          orow_q;
  logic [wlg_pkg::ColW-1:0]          ocol_q;

  logic [ColSW-1:0]                  ws_q [5];
  logic [PixW-1:0]                   cp_q [3];
  logic [wlg_pkg::TotalW-1:0]        total_q;
  logic [PixW-1:0]                   c_q;
  logic signed [wlg_pkg::WeightW-1:0] weighted_q;
  logic                              start_q;

  logic                              out_valid_q;
  logic [wlg_pkg::ChanW-1:0]         ob_q, og_q, or_q, oa_q;
  logic [wlg_pkg::RowW-1:0]          oorow_q;
  logic [wlg_pkg::ColW-1:0]          oocol_q;
  logic                              olast_q;

  logic                              acc;
  logic                              load;
  logic [wlg_pkg::WidthW-1:0]        w_eff;
  logic [wlg_pkg::HeightW-1:0]       h_eff;
  logic                              row_end, frame_end;
  logic [ColSW-1:0]                  colsum;
  logic [wlg_pkg::TotalW-1:0]        total;
  logic [WordW-1:0]                  wdata;
  logic [2:0]                        done;
  logic [wlg_pkg::ChanW-1:0]         res [3];

  assign acc         = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign load        = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    if (width_q < wlg_pkg::WidthW'(wlg_pkg::MinSize)) begin
      w_eff = wlg_pkg::WidthW'(wlg_pkg::MinSize);
    end else if (width_q > wlg_pkg::WidthW'(MAX_WIDTH)) begin
      w_eff = wlg_pkg::WidthW'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q < wlg_pkg::HeightW'(wlg_pkg::MinSize)) begin
      h_eff = wlg_pkg::HeightW'(wlg_pkg::MinSize);
    end else if (height_q > wlg_pkg::HeightW'(wlg_pkg::MaxHeight)) begin
      h_eff = wlg_pkg::HeightW'(wlg_pkg::MaxHeight);
    end else begin
      h_eff = height_q;
    end
    row_end   = {1'b0, col_cnt_q} >= w_eff - wlg_pkg::WidthW'(1);
    frame_end = row_end && ({1'b0, row_cnt_q} >= h_eff - wlg_pkg::HeightW'(1));
  end

  // column sum over five rows, window total with the new column, write-back word
  always_comb begin
    colsum = ColSW'(s_q);
    for (int k = 0; k < 4; k++) begin
      colsum = colsum + ColSW'(rdata_q[k*SumW +: SumW]);
    end
    total = wlg_pkg::TotalW'(colsum);
    for (int k = 0; k < 4; k++) begin
      total = total + wlg_pkg::TotalW'(ws_q[k]);
    end
    wdata = rdata_q;
    wdata[lane_q*SumW +: SumW] = s_q;
    wdata[4*SumW + lane_q[0]*PixW +: PixW] = pix_q;
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rdata_q <= mem[col_cnt_q[AddrW-1:0]];
    end
    if (state_q == S_READ) begin
      mem[addr_q] <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= '0;
      width_q  <= wlg_pkg::WidthW'(1024);
      height_q <= wlg_pkg::HeightW'(4096);
    end else if (cfg_we_i) begin
      case (wlg_pkg::cfg_idx_e'(cfg_idx_i))
        wlg_pkg::CFG_GAIN:   gain_q   <= cfg_data_i[wlg_pkg::GainW-1:0];
        wlg_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[wlg_pkg::WidthW-1:0];
        wlg_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 5; k++) ws_q[k] <= '0;
      for (int k = 0; k < 3; k++) cp_q[k] <= '0;
    end else begin
      start_q <= (state_q == S_MUL);
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (acc) begin
            addr_q     <= col_cnt_q[AddrW-1:0];
            lane_q     <= row_cnt_q[1:0];
            s_q        <= SumW'(in_i.red_in) + SumW'(in_i.green_in) + SumW'(in_i.blue_in);
            pix_q      <= {in_i.alpha_in, in_i.red_in, in_i.green_in, in_i.blue_in};
            interior_q <= (row_cnt_q >= wlg_pkg::RowW'(4)) && (col_cnt_q >= wlg_pkg::ColW'(4));
            last_q     <= frame_end;
            orow_q     <= row_cnt_q - wlg_pkg::RowW'(2);
            ocol_q     <= col_cnt_q - wlg_pkg::ColW'(2);
            if (row_end) begin
              col_cnt_q <= '0;
              row_cnt_q <= frame_end ? '0 : row_cnt_q + wlg_pkg::RowW'(1);
            end else begin
              col_cnt_q <= col_cnt_q + wlg_pkg::ColW'(1);
            end
            state_q <= S_READ;
          end
        end
        S_READ: begin
          for (int k = 4; k > 0; k--) ws_q[k] <= ws_q[k-1];
          ws_q[0] <= colsum;
          cp_q[2] <= cp_q[1];
          cp_q[1] <= cp_q[0];
          cp_q[0] <= rdata_q[4*SumW + lane_q[0]*PixW +: PixW];
          total_q <= total;
          c_q     <= cp_q[1];
          state_q <= interior_q ? S_MUL : S_IDLE;
        end
        S_MUL: begin
          weighted_q <= $signed({{(wlg_pkg::WeightW-wlg_pkg::TotalW){1'b0}}, total_q})
                        * wlg_pkg::WeightW'(gain_q);
          state_q    <= S_CHAN;
        end
        S_CHAN: begin
          if (done[0]) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (load) begin
            ob_q        <= res[0];
            og_q        <= res[1];
            or_q        <= res[2];
            oa_q        <= c_q[31:24];
            oorow_q     <= orow_q;
            oocol_q     <= ocol_q;
            olast_q     <= last_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_chan
    wlg_chan u_chan (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (start_q),
      .weighted_i (weighted_q),
      .chan_i     (c_q[i*wlg_pkg::ChanW +: wlg_pkg::ChanW]),
      .done_o     (done[i]),
      .result_o   (res[i])
    );
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.blue_out   = ob_q;
  assign out_o.green_out  = og_q;
  assign out_o.red_out    = or_q;
  assign out_o.alpha_out  = oa_q;
  assign out_o.out_row    = oorow_q;
  assign out_o.out_col    = oocol_q;
  assign out_o.frame_last = olast_q;

  a_acc_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> state_q == S_READ) else $error("accepted pixel did not read the line memory");
  a_done_in_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done[0] |-> state_q == S_CHAN) else $error("channel result outside wait state");
  a_chan_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done[0] |-> done[1] && done[2]) else $error("channel units out of step");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> $stable(ob_q) && out_valid_q)
    else $error("pending result overwritten");

endmodule
